### rtl/core/tgad_pkg.sv
// ----------------------------------------------------------------------------
// tgad_pkg
// Shared types, codes and header offsets of the TGA truecolor stream decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package tgad_pkg;

    localparam int FIFO_DEPTH_DEF = 4;
    localparam int CFG_INDEX_W    = 8;
    localparam int SHIFT_W        = 5;
    localparam int OUT_DATA_W     = 72;

    localparam logic [4:0] POS_TYPE      = 5'd2;
    localparam logic [4:0] POS_WIDTH_LO  = 5'd12;
    localparam logic [4:0] POS_WIDTH_HI  = 5'd13;
    localparam logic [4:0] POS_HEIGHT_LO = 5'd14;
    localparam logic [4:0] POS_HEIGHT_HI = 5'd15;
    localparam logic [4:0] POS_DEPTH     = 5'd16;
    localparam logic [4:0] POS_PIXELS    = 5'd17;

    localparam logic [7:0] TYPE_TRUECOLOR = 8'd2;
    localparam logic [7:0] DEPTH_24       = 8'd24;
    localparam logic [7:0] DEPTH_32       = 8'd32;
    localparam logic [7:0] ALPHA_OPAQUE   = 8'hff;

    localparam logic [CFG_INDEX_W-1:0] CFG_ALPHA = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_RED   = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_GREEN = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_BLUE  = 8'd3;

    localparam logic [SHIFT_W-1:0] ALPHA_SHIFT_RST = 5'd24;
    localparam logic [SHIFT_W-1:0] RED_SHIFT_RST   = 5'd16;
    localparam logic [SHIFT_W-1:0] GREEN_SHIFT_RST = 5'd8;
    localparam logic [SHIFT_W-1:0] BLUE_SHIFT_RST  = 5'd0;

    typedef enum logic [1:0] {PH_HEADER, PH_PIXELS, PH_DONE} t_phase;
    typedef enum logic [1:0] {KIND_HEADER, KIND_PIXEL, KIND_ERROR} t_kind;
    typedef enum logic [1:0] {ERR_NONE, ERR_TYPE, ERR_DEPTH, ERR_TRUNC} t_err;

    // data: pixel {a, r, g, b}; header {height, width}
    typedef struct packed {
        logic        has_main;
        t_kind       kind;
        logic [31:0] data;
        t_err        err;
        logic        last;
        logic        has_trunc;
    } t_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_status;

endpackage

`default_nettype wire

### rtl/core/tga_truecolor_stream_decoder_top.sv
// ----------------------------------------------------------------------------
// tga_truecolor_stream_decoder_top
// Byte-stream decoder for uncompressed 24/32-bit truecolor TGA images.
// Throughput: one byte per cycle while the request queue is not full; a byte
// that yields two results is queued once and expanded by the output side.
// Path: an accepted byte is written to the queue, then its result is loaded
// into the output register.
// Reset: synchronous active low; clears parser, queue pointers and output
// valid, loads default channel shifts.
// ----------------------------------------------------------------------------
`default_nettype none

module tga_truecolor_stream_decoder_top #(
    parameter int FIFO_DEPTH = tgad_pkg::FIFO_DEPTH_DEF
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              s_axis_tvalid,
    output logic                             s_axis_tready,
    input  wire  [7:0]                       s_axis_tdata,  // in_byte[7:0]
    input  wire                              s_axis_tlast,  // end_of_file
    output logic                             m_axis_tvalid,
    input  wire                              m_axis_tready,
    // pixel_word[31:0], image_width[47:32], image_height[63:48],
    // error_code[65:64], zero fill[71:66]
    output logic [tgad_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    output logic [1:0]                       m_axis_tuser,  // kind[1:0]
    output logic                             m_axis_tlast,  // last
    input  wire                              i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire  [tgad_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  wire  [tgad_pkg::SHIFT_W-1:0]     i_cfg_data
);
    import tgad_pkg::*;

    t_entry       push_entry;
    t_entry       head_entry;
    t_fifo_status fifo_status;
    logic         push;
    logic         pop;
    t_kind        out_kind;
    t_err         out_err;
    logic [31:0]  out_word;
    logic [15:0]  out_width;
    logic [15:0]  out_height;

    tgad_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (s_axis_tvalid),
        .o_ready       (s_axis_tready),
        .i_byte        (s_axis_tdata),
        .i_eof         (s_axis_tlast),
        .i_fifo_status (fifo_status),
        .o_push        (push),
        .o_entry       (push_entry)
    );

    tgad_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_wdata  (push_entry),
        .i_pop    (pop),
        .o_rdata  (head_entry),
        .o_status (fifo_status)
    );

    tgad_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_head        (head_entry),
        .i_fifo_status (fifo_status),
        .o_pop         (pop),
        .o_valid       (m_axis_tvalid),
        .i_ready       (m_axis_tready),
        .o_kind        (out_kind),
        .o_pixel_word  (out_word),
        .o_width       (out_width),
        .o_height      (out_height),
        .o_error_code  (out_err),
        .o_last        (m_axis_tlast)
    );

    assign o_cfg_ready  = 1'b1;
    assign m_axis_tuser = out_kind;
    assign m_axis_tdata = {6'd0, out_err, out_height, out_width, out_word};

endmodule

`default_nettype wire

### rtl/core/tgad_front.sv
// ----------------------------------------------------------------------------
// tgad_front
// Parses header bytes, gathers pixel bytes and queues result requests.
// ----------------------------------------------------------------------------
`default_nettype none

module tgad_front (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_valid,
    output logic            o_ready,
    input  wire  [7:0]      i_byte,
    input  wire             i_eof,
    input  tgad_pkg::t_fifo_status i_fifo_status,
    output logic            o_push,
    output tgad_pkg::t_entry o_entry
);
    import tgad_pkg::*;

    t_phase      r_phase, n_phase;
    logic [4:0]  r_pos, n_pos;
    logic [15:0] r_width, n_width;
    logic [15:0] r_height, n_height;
    logic        r_is32, n_is32;
    logic [31:0] r_pixels_left, n_pixels_left;
    logic [1:0]  r_byte_idx, n_byte_idx;
    logic [23:0] r_gathered, n_gathered;

    logic        accept;
    logic        fail;
    logic        final_byte;
    logic [7:0]  alpha;
    t_entry      entry;

    assign o_ready = !i_fifo_status.full;
    assign accept  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_HEADER;
            r_pos         <= '0;
            r_width       <= '0;
            r_height      <= '0;
            r_is32        <= 1'b0;
            r_pixels_left <= '0;
            r_byte_idx    <= '0;
            r_gathered    <= '0;
        end else begin
            r_phase       <= n_phase;
            r_pos         <= n_pos;
            r_width       <= n_width;
            r_height      <= n_height;
            r_is32        <= n_is32;
            r_pixels_left <= n_pixels_left;
            r_byte_idx    <= n_byte_idx;
            r_gathered    <= n_gathered;
        end
    end

    always_comb begin
        n_phase       = r_phase;
        n_pos         = r_pos;
        n_width       = r_width;
        n_height      = r_height;
        n_is32        = r_is32;
        n_pixels_left = r_pixels_left;
        n_byte_idx    = r_byte_idx;
        n_gathered    = r_gathered;
        fail          = 1'b0;
        final_byte    = 1'b0;
        alpha         = ALPHA_OPAQUE;
        entry         = '0;

        if (accept) begin
            unique case (r_phase)
                PH_HEADER: begin
                    if (r_pos == POS_TYPE && i_byte != TYPE_TRUECOLOR) begin
                        entry.has_main = 1'b1;
                        entry.kind     = KIND_ERROR;
                        entry.err      = ERR_TYPE;
                        entry.last     = 1'b1;
                        n_phase        = PH_DONE;
                        fail           = 1'b1;
                    end else if (r_pos == POS_WIDTH_LO) begin
                        n_width[7:0] = i_byte;
                    end else if (r_pos == POS_WIDTH_HI) begin
                        n_width[15:8] = i_byte;
                    end else if (r_pos == POS_HEIGHT_LO) begin
                        n_height[7:0] = i_byte;
                    end else if (r_pos == POS_HEIGHT_HI) begin
                        n_height[15:8] = i_byte;
                    end else if (r_pos == POS_DEPTH) begin
                        n_is32 = (i_byte == DEPTH_32);
                        if (i_byte != DEPTH_24 && i_byte != DEPTH_32) begin
                            entry.has_main = 1'b1;
                            entry.kind     = KIND_ERROR;
                            entry.err      = ERR_DEPTH;
                            entry.last     = 1'b1;
                            n_phase        = PH_DONE;
                            fail           = 1'b1;
                        end
                    end else if (r_pos >= POS_PIXELS) begin
                        n_pixels_left  = 32'(r_width) * 32'(r_height);
                        entry.has_main = 1'b1;
                        entry.kind     = KIND_HEADER;
                        entry.data     = {r_height, r_width};
                        entry.last     = (r_width == '0) || (r_height == '0);
                        n_phase        = entry.last ? PH_DONE : PH_PIXELS;
                        n_byte_idx     = '0;
                        n_gathered     = '0;
                        fail           = 1'b1;
                    end
                    if (!fail) begin
                        n_pos = r_pos + 5'd1;
                    end
                end
                PH_PIXELS: begin
                    case (r_byte_idx)
                        2'd0:    n_gathered[7:0]   = r_gathered[7:0]   | i_byte;
                        2'd1:    n_gathered[15:8]  = r_gathered[15:8]  | i_byte;
                        2'd2:    n_gathered[23:16] = r_gathered[23:16] | i_byte;
                        default: n_gathered        = r_gathered;
                    endcase
                    final_byte = r_is32 ? (r_byte_idx == 2'd3) : (r_byte_idx >= 2'd2);
                    if (final_byte) begin
                        alpha          = r_is32 ? i_byte : ALPHA_OPAQUE;
                        n_pixels_left  = r_pixels_left - 32'd1;
                        entry.has_main = 1'b1;
                        entry.kind     = KIND_PIXEL;
                        entry.data     = {alpha, n_gathered};
                        entry.last     = (r_pixels_left == 32'd1);
                        if (entry.last) begin
                            n_phase = PH_DONE;
                        end
                        n_byte_idx = '0;
                        n_gathered = '0;
                    end else begin
                        n_byte_idx = r_byte_idx + 2'd1;
                    end
                end
                PH_DONE: begin
                end
                default: begin
                end
            endcase

            if (i_eof) begin
                entry.has_trunc = (n_phase != PH_DONE);
                n_phase         = PH_HEADER;
                n_pos           = '0;
                n_width         = '0;
                n_height        = '0;
                n_is32          = 1'b0;
                n_pixels_left   = '0;
                n_byte_idx      = '0;
                n_gathered      = '0;
            end
        end
    end

    assign o_entry = entry;
    assign o_push  = entry.has_main || entry.has_trunc;

endmodule

`default_nettype wire

### rtl/core/tgad_fifo.sv
// ----------------------------------------------------------------------------
// tgad_fifo
// Short request queue between the parser and the result formatter.
// ----------------------------------------------------------------------------
`default_nettype none

module tgad_fifo #(
    parameter int DEPTH = tgad_pkg::FIFO_DEPTH_DEF
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_push,
    input  tgad_pkg::t_entry i_wdata,
    input  wire              i_pop,
    output tgad_pkg::t_entry o_rdata,
    output tgad_pkg::t_fifo_status o_status
);
    import tgad_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    t_entry           r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + CNT_W'(1);
            2'b01:   n_count = r_count - CNT_W'(1);
            default: n_count = r_count;
        endcase
    end

    assign o_rdata        = r_mem[r_rd_ptr];
    assign o_status.full  = (r_count == FULL_CNT);
    assign o_status.empty = (r_count == '0);

endmodule

`default_nettype wire

### rtl/core/tgad_back.sv
// ----------------------------------------------------------------------------
// tgad_back
// Expands queued requests into results, packs pixel channels, holds config.
// ----------------------------------------------------------------------------
`default_nettype none

module tgad_back (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_cfg_valid,
    input  wire  [tgad_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  wire  [tgad_pkg::SHIFT_W-1:0]        i_cfg_data,
    input  tgad_pkg::t_entry                    i_head,
    input  tgad_pkg::t_fifo_status              i_fifo_status,
    output logic                                o_pop,
    output logic                                o_valid,
    input  wire                                 i_ready,
    output tgad_pkg::t_kind                     o_kind,
    output logic [31:0]                         o_pixel_word,
    output logic [15:0]                         o_width,
    output logic [15:0]                         o_height,
    output tgad_pkg::t_err                      o_error_code,
    output logic                                o_last
);
    import tgad_pkg::*;

    logic [SHIFT_W-1:0] r_alpha_sh, r_red_sh, r_green_sh, r_blue_sh;

    logic        r_valid, n_valid;
    logic        r_sub, n_sub;
    t_kind       r_kind, n_kind;
    logic [31:0] r_word, n_word;
    logic [15:0] r_width, n_width;
    logic [15:0] r_height, n_height;
    t_err        r_err, n_err;
    logic        r_last, n_last;

    logic        load;
    logic        pick_trunc;

    function automatic logic [31:0] place(input logic [7:0] v, input logic [SHIFT_W-1:0] sh);
        place = {24'd0, v} << sh;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha_sh <= ALPHA_SHIFT_RST;
            r_red_sh   <= RED_SHIFT_RST;
            r_green_sh <= GREEN_SHIFT_RST;
            r_blue_sh  <= BLUE_SHIFT_RST;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_ALPHA) begin
                r_alpha_sh <= i_cfg_data;
            end
            if (i_cfg_index == CFG_RED) begin
                r_red_sh <= i_cfg_data;
            end
            if (i_cfg_index == CFG_GREEN) begin
                r_green_sh <= i_cfg_data;
            end
            if (i_cfg_index == CFG_BLUE) begin
                r_blue_sh <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sub   <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_sub   <= n_sub;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind   <= n_kind;
        r_word   <= n_word;
        r_width  <= n_width;
        r_height <= n_height;
        r_err    <= n_err;
        r_last   <= n_last;
    end

    always_comb begin
        load       = (!r_valid || i_ready) && !i_fifo_status.empty;
        pick_trunc = r_sub || !i_head.has_main;
        o_pop      = load && (pick_trunc || !i_head.has_trunc);
        n_valid    = r_valid && !i_ready;
        n_sub      = r_sub;
        n_kind     = r_kind;
        n_word     = r_word;
        n_width    = r_width;
        n_height   = r_height;
        n_err      = r_err;
        n_last     = r_last;

        if (load) begin
            n_valid  = 1'b1;
            n_sub    = !pick_trunc && i_head.has_trunc;
            n_word   = '0;
            n_width  = '0;
            n_height = '0;
            if (pick_trunc) begin
                n_kind = KIND_ERROR;
                n_err  = ERR_TRUNC;
                n_last = 1'b1;
            end else begin
                n_kind = i_head.kind;
                n_err  = i_head.err;
                n_last = i_head.last;
                unique case (i_head.kind)
                    KIND_PIXEL: begin
                        n_word = place(i_head.data[31:24], r_alpha_sh)
                               | place(i_head.data[23:16], r_red_sh)
                               | place(i_head.data[15:8],  r_green_sh)
                               | place(i_head.data[7:0],   r_blue_sh);
                    end
                    KIND_HEADER: begin
                        n_width  = i_head.data[15:0];
                        n_height = i_head.data[31:16];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    assign o_valid      = r_valid;
    assign o_kind       = r_kind;
    assign o_pixel_word = r_word;
    assign o_width      = r_width;
    assign o_height     = r_height;
    assign o_error_code = r_err;
    assign o_last       = r_last;

endmodule

`default_nettype wire

### rtl/core/tgad_checker.sv
// ----------------------------------------------------------------------------
// tgad_checker
// Port-level checks on the result stream of the TGA decoder.
// ----------------------------------------------------------------------------
`default_nettype none

module tgad_checker (
    input wire                              i_clk,
    input wire                              i_rst_n,
    input wire                              m_axis_tvalid,
    input wire                              m_axis_tready,
    input wire [tgad_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    input wire [1:0]                        m_axis_tuser,
    input wire                              m_axis_tlast
);
    import tgad_pkg::*;

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("stalled result changed");

    a_error_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == KIND_ERROR |->
            m_axis_tlast && m_axis_tdata[65:64] != ERR_NONE && m_axis_tdata[63:0] == '0)
        else $error("malformed error result");

    a_pixel_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == KIND_PIXEL |-> m_axis_tdata[71:32] == '0)
        else $error("pixel result carries header or error fields");

    a_header_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == KIND_HEADER |->
            m_axis_tdata[31:0] == '0 && m_axis_tdata[71:64] == '0
            && m_axis_tlast == (m_axis_tdata[47:32] == '0 || m_axis_tdata[63:48] == '0))
        else $error("malformed header result");

endmodule

bind tga_truecolor_stream_decoder_top tgad_checker u_tgad_checker (.*);

`default_nettype wire
